@@ design/rca_pkg.sv @@
package rca_pkg;

	// Transaction kinds carried on the mode field.
	typedef enum logic [2:0] {
		MODE_READ_WORD  = 3'd0,
		MODE_WRITE_WORD = 3'd1,
		MODE_READ_BYTE  = 3'd2,
		MODE_WRITE_BYTE = 3'd3,
		MODE_TICK       = 3'd4
	} mode_t;

	// Register offsets from the block base.
	localparam logic [15:0] OFF_ALARM   = 16'h0000;
	localparam logic [15:0] OFF_COUNTER = 16'h0004;
	localparam logic [15:0] OFF_TRIM    = 16'h0008;
	localparam logic [15:0] OFF_STATUS  = 16'h0010;

	localparam int TRIM_W   = 26;
	localparam int STATUS_W = 4;

	// Status bit positions. The two flags are write-one-to-clear.
	localparam int ST_AL  = 0;
	localparam int ST_HZ  = 1;
	localparam int ST_ALE = 2;
	localparam int ST_HZE = 3;

	localparam logic [STATUS_W-1:0] FLAG_BITS   = 4'h3;
	localparam logic [STATUS_W-1:0] ENABLE_BITS = 4'hC;

endpackage

@@ design/rtc_counter_alarm_registers_core.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------------
// input    | in_valid / in_stall   | mode, offset, write_data
// output   | out_valid / out_stall | read_data, access_error, alarm_irq, hz_irq
//
// Every input transaction yields exactly one output transaction, through the input
// register and then the output register. One transaction can be accepted every cycle while in_stall is low.
// A transaction sits in the input register, then the register file is read,
// updated and the result captured in the output register together.
// arst_n clears the register file and both valid bits asynchronously.
// While the output register holds a stalled result, the input register still
// takes one more transaction; in_stall rises only when both stages are full.
module rtc_counter_alarm_registers_core
	import rca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        access_error,
	output logic        alarm_irq,
	output logic        hz_irq
);

	// Input stage.
	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [15:0] offset_s1;
	logic [31:0] wdata_s1;

	// Register file.
	logic [31:0]         alarm_q;
	logic [31:0]         count_q;
	logic [TRIM_W-1:0]   trim_q;
	logic [STATUS_W-1:0] status_q;

	// Output stage.
	logic        valid_s2;
	logic [31:0] rdata_s2;
	logic        err_s2;
	logic        alarm_irq_s2;
	logic        hz_irq_s2;

	logic        load_s2;
	logic        take_s1;
	logic        is_byte;
	logic        is_read;
	logic        is_write;
	logic        is_access;
	logic [15:0] word_addr;
	logic        hit_alarm;
	logic        hit_count;
	logic        hit_trim;
	logic        hit_status;
	logic        hit_any;
	logic [31:0] cur_word;
	logic [4:0]  lane_shift;
	logic [31:0] lane_mask;
	logic [31:0] merged;
	logic [31:0] wval;
	logic        do_write;
	logic        do_tick;
	logic [31:0] count_inc;
	logic [31:0] count_d;
	logic [31:0] alarm_d;
	logic [TRIM_W-1:0]   trim_d;
	logic [STATUS_W-1:0] status_d;
	logic [STATUS_W-1:0] status_wr;
	logic [31:0] rdata_d;
	logic        err_d;

	// The output register loads whenever it is empty or being drained.
	assign load_s2  = !valid_s2 || !out_stall;
	assign take_s1  = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1   <= mode;
			offset_s1 <= offset;
			wdata_s1  <= write_data;
		end
	end

	// Decode. Byte accesses drop the lane bits to find the register.
	always_comb begin
		is_byte   = (mode_s1 == MODE_READ_BYTE) || (mode_s1 == MODE_WRITE_BYTE);
		is_read   = (mode_s1 == MODE_READ_WORD) || (mode_s1 == MODE_READ_BYTE);
		is_write  = (mode_s1 == MODE_WRITE_WORD) || (mode_s1 == MODE_WRITE_BYTE);
		is_access = is_read || is_write;
		word_addr = is_byte ? {offset_s1[15:2], 2'b00} : offset_s1;
		hit_alarm  = (word_addr == OFF_ALARM);
		hit_count  = (word_addr == OFF_COUNTER);
		hit_trim   = (word_addr == OFF_TRIM);
		hit_status = (word_addr == OFF_STATUS);
		hit_any    = hit_alarm || hit_count || hit_trim || hit_status;
	end

	always_comb begin
		cur_word = 32'd0;
		if (hit_alarm) begin
			cur_word = alarm_q;
		end else if (hit_count) begin
			cur_word = count_q;
		end else if (hit_trim) begin
			cur_word = {{(32-TRIM_W){1'b0}}, trim_q};
		end else if (hit_status) begin
			cur_word = {{(32-STATUS_W){1'b0}}, status_q};
		end
	end

	// Byte lane merge for byte writes; word writes pass straight through.
	always_comb begin
		lane_shift = {offset_s1[1:0], 3'b000};
		lane_mask  = 32'h0000_00FF << lane_shift;
		merged     = (cur_word & ~lane_mask)
			| ({24'd0, wdata_s1[7:0]} << lane_shift);
		wval       = is_byte ? merged : wdata_s1;
	end

	assign do_write  = take_s1 && is_write && hit_any;
	assign do_tick   = take_s1 && (mode_s1 == MODE_TICK);
	assign count_inc = count_q + 32'd1;

	// Next register values.
	always_comb begin
		alarm_d   = alarm_q;
		count_d   = count_q;
		trim_d    = trim_q;
		status_d  = status_q;
		status_wr = (status_q & ~wval[STATUS_W-1:0] & FLAG_BITS)
			| (wval[STATUS_W-1:0] & ENABLE_BITS);
		if (do_write) begin
			if (hit_alarm) begin
				alarm_d = wval;
			end
			if (hit_count) begin
				count_d = wval;
			end
			if (hit_trim) begin
				trim_d = wval[TRIM_W-1:0];
			end
			if (hit_status) begin
				status_d = status_wr;
			end
		end else if (do_tick) begin
			count_d         = count_inc;
			status_d[ST_HZ] = 1'b1;
			if (count_inc == alarm_q) begin
				status_d[ST_AL] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q  <= 32'd0;
			count_q  <= 32'd0;
			trim_q   <= '0;
			status_q <= '0;
		end else begin
			alarm_q  <= alarm_d;
			count_q  <= count_d;
			trim_q   <= trim_d;
			status_q <= status_d;
		end
	end

	// Result word: the register or its lane on a good read, zero otherwise.
	always_comb begin
		err_d   = is_access && !hit_any;
		rdata_d = 32'd0;
		if (is_read && hit_any) begin
			if (is_byte) begin
				rdata_d = (cur_word >> lane_shift) & 32'h0000_00FF;
			end else begin
				rdata_d = cur_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rdata_s2     <= rdata_d;
			err_s2       <= err_d;
			alarm_irq_s2 <= status_d[ST_AL] && status_d[ST_ALE];
			hz_irq_s2    <= status_d[ST_HZ] && status_d[ST_HZE];
		end
	end

	assign out_valid    = valid_s2;
	assign read_data    = rdata_s2;
	assign access_error = err_s2;
	assign alarm_irq    = alarm_irq_s2;
	assign hz_irq       = hz_irq_s2;

endmodule
